FILE: design/gcrf_pkg.sv
// Shared types, constants and tables of the great-circle range filter.
package gcrf_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_STEPS    = 31;
    // Register stages from the input register to the distance register.
    localparam int LAT           = 6 + 2 * CORDIC_STAGES + SQRT_STEPS;

    localparam int AW = 34;   // Q30 angle and trig width
    localparam int RW = 36;   // width before angle reduction
    localparam int SW = 62;   // square root working width
    localparam int MW = 32;   // multiplier operand width

    localparam logic signed [RW-1:0] R_PI      = 36'sd3373259426;
    localparam logic signed [RW-1:0] R_HALF_PI = 36'sd1686629713;
    localparam logic signed [RW-1:0] R_TWO_PI  = 36'sd6746518852;
    localparam logic signed [AW-1:0] GAIN_INV  = 34'sd652032874;
    localparam logic [30:0]          Q30_ONE   = 31'd1073741824;
    localparam logic [19:0]          DIST_MAX  = 20'hFFFFF;

    localparam logic [2:0] REG_ORIGIN_LAT = 3'd0;
    localparam logic [2:0] REG_ORIGIN_LON = 3'd1;
    localparam logic [2:0] REG_RANGE      = 3'd2;
    localparam logic [2:0] REG_WINDOW     = 3'd3;
    localparam logic [2:0] REG_RADIUS     = 3'd4;

    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 flip;
    } t_rot;

    typedef struct packed {
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] y;
        logic signed [AW-1:0] z;
    } t_vec;

    typedef struct packed {
        logic [SW-1:0] v;
        logic [SW-1:0] res;
    } t_sq;

    function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0:  r = 34'sd843314857;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043837;
            5'd3:  r = 34'sd133525159;
            5'd4:  r = 34'sd67021687;
            5'd5:  r = 34'sd33543516;
            5'd6:  r = 34'sd16775851;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194283;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            5'd24: r = 34'sd64;
            5'd25: r = 34'sd32;
            5'd26: r = 34'sd16;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Brings any angle within [-5*pi, 5*pi] into [-pi/2, pi/2]; the flip bit negates the cosine.
    function automatic t_rot angle_prep(input logic signed [RW-1:0] a_in);
        logic signed [RW-1:0] a;
        t_rot r;
        a = a_in;
        r.flip = 1'b0;
        if (a > R_PI) a = a - R_TWO_PI;
        if (a > R_PI) a = a - R_TWO_PI;
        if (a < -R_PI) a = a + R_TWO_PI;
        if (a < -R_PI) a = a + R_TWO_PI;
        if (a > R_HALF_PI) begin
            a = R_PI - a;
            r.flip = 1'b1;
        end else if (a < -R_HALF_PI) begin
            a = -R_PI - a;
            r.flip = 1'b1;
        end
        r.x = GAIN_INV;
        r.y = '0;
        r.z = a[AW-1:0];
        return r;
    endfunction

endpackage

FILE: design/gcrf_rot_cell.sv
// One rotation-mode CORDIC iteration with its output register.
module gcrf_rot_cell import gcrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_stage,
    input  t_rot       i_d,
    output t_rot       o_d
);

    t_rot r_d;
    t_rot n_d;
    logic signed [AW-1:0] xs;
    logic signed [AW-1:0] ys;
    logic signed [AW-1:0] at;

    always_comb begin
        xs = i_d.x >>> i_stage;
        ys = i_d.y >>> i_stage;
        at = atan_q30(i_stage);
        n_d = i_d;
        if (i_d.z >= 0) begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - at;
        end else begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: design/gcrf_sqrt_cell.sv
// One step of the bit-serial integer square root with its output register.
module gcrf_sqrt_cell import gcrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_step,
    input  t_sq        i_d,
    output t_sq        o_d
);

    t_sq r_d;
    t_sq n_d;
    logic [SW-1:0] bitv;
    logic [SW-1:0] trial;

    always_comb begin
        bitv  = SW'(1) << (6'd60 - {i_step, 1'b0});
        trial = i_d.res + bitv;
        if (i_d.v >= trial) begin
            n_d.v   = i_d.v - trial;
            n_d.res = (i_d.res >> 1) + bitv;
        end else begin
            n_d.v   = i_d.v;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: design/gcrf_vec_cell.sv
// One vectoring-mode CORDIC iteration with its output register.
module gcrf_vec_cell import gcrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [4:0] i_stage,
    input  t_vec       i_d,
    output t_vec       o_d
);

    t_vec r_d;
    t_vec n_d;
    logic signed [AW-1:0] xs;
    logic signed [AW-1:0] ys;
    logic signed [AW-1:0] at;

    always_comb begin
        xs = i_d.x >>> i_stage;
        ys = i_d.y >>> i_stage;
        at = atan_q30(i_stage);
        if (i_d.y >= 0) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + at;
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

FILE: design/great_circle_range_filter.sv
// Top level of the great-circle range filter: haversine distance pipeline.
// The filter takes one table entry per clock cycle while o_stall is low and returns
// one result per entry, in order. Each entry flows through four rows of CORDIC
// sine/cosine cells, three multiply stages, two rows of 31 square-root cells, a row
// of vectoring CORDIC cells for the arctangent, and scale, round and compare stages.
// An output register plus one skid register let the pipeline keep moving while a
// result waits; o_stall rises only once the skid register is also occupied.
// Configuration writes take effect immediately and should be made only while no
// entry is in flight.
module great_circle_range_filter import gcrf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [22:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [21:0] i_latitude,
    input  logic signed [22:0] i_longitude,
    input  logic [14:0]        i_entry_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [14:0]        o_result_index,
    output logic [19:0]        o_distance,
    output logic               o_accepted
);

    // Configuration registers.
    logic signed [21:0] r_olat;
    logic signed [22:0] r_olon;
    logic [19:0]        r_range;
    logic               r_window;
    logic [15:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olat   <= '0;
            r_olon   <= '0;
            r_range  <= 20'd1600;
            r_window <= 1'b1;
            r_radius <= 16'd53442;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ORIGIN_LAT: r_olat   <= i_cfg_data[21:0];
                REG_ORIGIN_LON: r_olon   <= i_cfg_data;
                REG_RANGE:      r_range  <= i_cfg_data[19:0];
                REG_WINDOW:     r_window <= i_cfg_data[0];
                REG_RADIUS:     r_radius <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together unless the skid register is full.
    logic en;
    logic r_skid_v;
    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    logic        r_v   [LAT];
    logic [14:0] r_idx [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx[0] <= i_entry_index;
            for (int k = 1; k < LAT; k++) r_idx[k] <= r_idx[k-1];
        end
    end

    // Angle preparation: half differences and full latitudes, reduced and folded.
    logic signed [RW-1:0] a_dlat;
    logic signed [RW-1:0] a_dlon;
    logic signed [RW-1:0] a_olat;
    logic signed [RW-1:0] a_lat;
    t_rot r_prep [4];

    always_comb begin
        a_dlat = (RW'(i_latitude) - RW'(r_olat)) <<< 9;
        a_dlon = (RW'(i_longitude) - RW'(r_olon)) <<< 9;
        a_olat = RW'(r_olat) <<< 10;
        a_lat  = RW'(i_latitude) <<< 10;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prep[0] <= angle_prep(a_dlat);
            r_prep[1] <= angle_prep(a_dlon);
            r_prep[2] <= angle_prep(a_olat);
            r_prep[3] <= angle_prep(a_lat);
        end
    end

    t_rot w_rot [4][CORDIC_STAGES+1];

    for (genvar c = 0; c < 4; c++) begin : g_rot
        assign w_rot[c][0] = r_prep[c];
        for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            gcrf_rot_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_stage (5'(s)),
                .i_d     (w_rot[c][s]),
                .o_d     (w_rot[c][s+1])
            );
        end
    end

    // Haversine term h = s1^2 + cos(olat) cos(lat) s2^2, in three multiply stages.
    logic signed [MW-1:0]   s1;
    logic signed [MW-1:0]   s2;
    logic signed [MW-1:0]   co;
    logic signed [MW-1:0]   cl;
    logic signed [2*MW-1:0] p_cc;
    logic signed [2*MW-1:0] p_s1;
    logic signed [2*MW-1:0] p_s2;
    logic signed [AW-1:0]   r_tmp;
    logic signed [AW-1:0]   r_a;
    logic signed [AW-1:0]   r_b;
    logic signed [2*MW-1:0] p_tb;
    logic signed [AW-1:0]   r_a2;
    logic signed [AW-1:0]   r_p;
    logic signed [AW:0]     h_sum;
    logic [30:0]            n_h;
    logic [30:0]            r_h;

    always_comb begin
        s1 = w_rot[0][CORDIC_STAGES].y[MW-1:0];
        s2 = w_rot[1][CORDIC_STAGES].y[MW-1:0];
        co = w_rot[2][CORDIC_STAGES].flip ? -w_rot[2][CORDIC_STAGES].x[MW-1:0]
                                          : w_rot[2][CORDIC_STAGES].x[MW-1:0];
        cl = w_rot[3][CORDIC_STAGES].flip ? -w_rot[3][CORDIC_STAGES].x[MW-1:0]
                                          : w_rot[3][CORDIC_STAGES].x[MW-1:0];
        p_cc = co * cl;
        p_s1 = s1 * s1;
        p_s2 = s2 * s2;
        // The cosine product goes negative when a latitude folds past a pole.
        p_tb = signed'(r_tmp[MW-1:0]) * signed'(r_b[MW-1:0]);
        h_sum = (AW+1)'(r_a2) + (AW+1)'(r_p);
        if (h_sum < 0) begin
            n_h = '0;
        end else if (h_sum > (AW+1)'(Q30_ONE)) begin
            n_h = Q30_ONE;
        end else begin
            n_h = h_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tmp <= p_cc[2*MW-1:30];
            r_a   <= p_s1[2*MW-1:30];
            r_b   <= p_s2[2*MW-1:30];
            r_p   <= p_tb[2*MW-1:30];
            r_a2  <= r_a;
            r_h   <= n_h;
        end
    end

    // Square roots of h and 1 - h.
    t_sq w_sq [2][SQRT_STEPS+1];

    assign w_sq[0][0] = '{v: {1'b0, r_h, 30'd0}, res: '0};
    assign w_sq[1][0] = '{v: {1'b0, Q30_ONE - r_h, 30'd0}, res: '0};

    for (genvar c = 0; c < 2; c++) begin : g_sq
        for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
            gcrf_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_step (5'(s)),
                .i_d    (w_sq[c][s]),
                .o_d    (w_sq[c][s+1])
            );
        end
    end

    // Central half angle atan2(sqrt h, sqrt(1 - h)).
    t_vec w_vec [CORDIC_STAGES+1];

    assign w_vec[0] = '{x: AW'(w_sq[1][SQRT_STEPS].res[31:0]),
                        y: AW'(w_sq[0][SQRT_STEPS].res[31:0]),
                        z: '0};

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
        gcrf_vec_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_stage (5'(s)),
            .i_d     (w_vec[s]),
            .o_d     (w_vec[s+1])
        );
    end

    // Scale by the radius, round half up and saturate.
    logic [AW-1:0]    ang;
    logic [AW+15:0]   r_prod;
    logic [AW+15:0]   rounded;
    logic [19:0]      n_dist;
    logic [19:0]      r_dist;

    always_comb begin
        if (w_vec[CORDIC_STAGES].z < 0) begin
            ang = '0;
        end else begin
            ang = {w_vec[CORDIC_STAGES].z[AW-2:0], 1'b0};
        end
        rounded = r_prod + ((AW+16)'(1) << 29);
        if (rounded[AW+15:30] > (AW-14)'(DIST_MAX)) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = rounded[49:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= ang * r_radius;
            r_dist <= n_dist;
        end
    end

    // Range test.
    logic [24:0] d10;
    logic [24:0] rng9;
    logic [24:0] rng11;
    logic        acc;

    always_comb begin
        d10   = 25'(r_dist) * 25'd10;
        rng9  = 25'(r_range) * 25'd9;
        rng11 = 25'(r_range) * 25'd11;
        if (r_window) begin
            acc = (d10 > rng9) && (d10 < rng11);
        end else begin
            acc = r_dist < r_range;
        end
        if (r_dist == '0) begin
            acc = 1'b0;
        end
    end

    // Output register and skid register.
    logic        r_out_v;
    logic [14:0] r_out_idx;
    logic [19:0] r_out_dist;
    logic        r_out_acc;
    logic [14:0] r_skid_idx;
    logic [19:0] r_skid_dist;
    logic        r_skid_acc;
    logic        end_v;
    logic        take_out;

    assign end_v    = r_v[LAT-1];
    assign take_out = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take_out) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= end_v;
            end
        end else if (!r_skid_v && end_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out) begin
            if (r_skid_v) begin
                r_out_idx  <= r_skid_idx;
                r_out_dist <= r_skid_dist;
                r_out_acc  <= r_skid_acc;
            end else begin
                r_out_idx  <= r_idx[LAT-1];
                r_out_dist <= r_dist;
                r_out_acc  <= acc;
            end
        end else if (!r_skid_v) begin
            r_skid_idx  <= r_idx[LAT-1];
            r_skid_dist <= r_dist;
            r_skid_acc  <= acc;
        end
    end

    assign o_valid        = r_out_v;
    assign o_result_index = r_out_idx;
    assign o_distance     = r_out_dist;
    assign o_accepted     = r_out_acc;

endmodule
